// File: design/brb_pkg.sv
package brb_pkg;

  // Store geometry
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned MAX_READ = 64;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = PTR_W + 1;

  // Field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned WLEN_W  = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RLEN_W  = 7;
  localparam int unsigned KIND_W  = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_EN   = 1'b1;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WR_OK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_REJ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_BYTE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_EMPTY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd4;

endpackage

// File: design/brb_if.sv
interface brb_in_if;
  import brb_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              first_byte;
  logic [WLEN_W-1:0] write_length;
  logic [BYTE_W-1:0] data_byte;
  logic [RLEN_W-1:0] read_length;

  modport source (
    output valid, mode, first_byte, write_length, data_byte, read_length,
    input  ready
  );
  modport sink (
    input  valid, mode, first_byte, write_length, data_byte, read_length,
    output ready
  );
endinterface

interface brb_out_if;
  import brb_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] read_byte;
  logic [RLEN_W-1:0] returned_length;
  logic              last;

  modport source (
    output valid, kind, read_byte, returned_length, last,
    input  ready
  );
  modport sink (
    input  valid, kind, read_byte, returned_length, last,
    output ready
  );
endinterface

// File: design/brb_store.sv
module brb_store (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [brb_pkg::PTR_W-1:0] wr_addr_i,
  input  logic [brb_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [brb_pkg::PTR_W-1:0] rd_addr_i,
  output logic [brb_pkg::BYTE_W-1:0] rd_data_o
);
  import brb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: design/byte_ring_buffer_with_padding_unit.sv
// Channel  | Dir | Payload                                         | Handshake
// ---------+-----+-------------------------------------------------+------------
// in_i     | in  | mode, first_byte, write_length, data_byte,      | valid/ready
//          |     | read_length                                     |
// out_o    | out | kind, read_byte, returned_length, last          | valid/ready
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i                 | write enable
//
// Write bytes, clears and empty reads each give one result. A read of n
// bytes streams n results, one per cycle while out_o is not stalled,
// through the registered store read port; the input is not ready again
// until every byte has been issued and the last one loaded into the output
// register. Reset clears pointers and counters at once; the byte store is
// not cleared. A stall on out_o holds the store read data and stops issue.
module byte_ring_buffer_with_padding_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  brb_in_if.sink                        in_i,
  brb_out_if.source                     out_o
);
  import brb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Control state
  logic              state_q, state_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic              pad_en_q, pad_en_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [PTR_W-1:0]  pad_q, pad_d;
  logic [WLEN_W-1:0] rem_q, rem_d;
  logic              drop_q, drop_d;
  logic [RLEN_W-1:0] rd_left_q, rd_left_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  // Payload
  logic [RLEN_W-1:0] rd_len_q, rd_len_d;
  logic              pend_last_q, pend_last_d;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [RLEN_W-1:0] out_len_q, out_len_d;
  logic              out_last_q, out_last_d;

  logic              in_acc, out_free, load_rd, issue;
  logic              wr_store, wr_ok, pad_now;
  logic [CNT_W-1:0]  avail, tail, wp_inc;
  logic [PTR_W-1:0]  wp_eff;
  logic [CNT_W-1:0]  end_cur, rp_inc;
  logic              pre_wrap, post_wrap;
  logic [PTR_W-1:0]  rd_rp, rd_pad;
  logic [RLEN_W-1:0] want, n_rd;
  logic [BYTE_W-1:0] rd_data;
  logic [CNT_W-1:0]  cap_new;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // Admission check of a write transaction; padding moves it to address 0.
  // Only the first byte of a transaction may skip the tail.
  always_comb begin
    avail   = cap_q - used_q - {1'b0, pad_q};
    tail    = cap_q - {1'b0, wp_q};
    wr_ok   = (in_i.write_length != '0) && (in_i.write_length <= avail);
    pad_now = 1'b0;
    if (in_i.first_byte && wr_ok && ((used_q == '0) || (wp_q > rp_q))
        && (in_i.write_length > tail) && pad_en_q) begin
      if (in_i.write_length > {1'b0, rp_q}) begin
        wr_ok = 1'b0;
      end else begin
        pad_now = 1'b1;
      end
    end
    if (in_i.first_byte) begin
      wr_store = wr_ok;
    end else begin
      wr_store = (rem_q != '0) && !drop_q;
    end
    wp_eff = pad_now ? '0 : wp_q;
    wp_inc = {1'b0, wp_eff} + CNT_W'(1);
  end

  // Read pointer for the next byte: wrap past the used area, drop padding.
  always_comb begin
    end_cur   = cap_q - {1'b0, pad_q};
    pre_wrap  = {1'b0, rp_q} >= end_cur;
    rd_rp     = pre_wrap ? '0 : rp_q;
    rd_pad    = pre_wrap ? '0 : pad_q;
    rp_inc    = {1'b0, rd_rp} + CNT_W'(1);
    post_wrap = rp_inc >= (cap_q - {1'b0, rd_pad});
  end

  // Requested length clamped to 1..MAX_READ, then to the bytes held
  always_comb begin
    if (in_i.read_length == '0) begin
      want = RLEN_W'(1);
    end else if (in_i.read_length > RLEN_W'(MAX_READ)) begin
      want = RLEN_W'(MAX_READ);
    end else begin
      want = in_i.read_length;
    end
    n_rd = ({{(CNT_W-RLEN_W){1'b0}}, want} < used_q) ? want : used_q[RLEN_W-1:0];
  end

  assign load_rd = pend_q && out_free;
  assign issue   = (state_q == ST_READ) && (rd_left_q != '0) && (!pend_q || load_rd);

  // Clamped capacity for a configuration write
  always_comb begin
    cap_new = cfg_data_i;
    if (cap_new == '0) begin
      cap_new = CNT_W'(1);
    end else if (cap_new > CNT_W'(DEPTH)) begin
      cap_new = CNT_W'(DEPTH);
    end
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    pad_en_d    = pad_en_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    used_d      = used_q;
    pad_d       = pad_q;
    rem_d       = rem_q;
    drop_d      = drop_q;
    rd_left_d   = rd_left_q;
    rd_len_d    = rd_len_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY: begin
          cap_d  = cap_new;
          wp_d   = '0;
          rp_d   = '0;
          used_d = '0;
          pad_d  = '0;
          rem_d  = '0;
          drop_d = 1'b0;
        end
        CFG_PAD_EN: pad_en_d = cfg_data_i[0];
        default: ;
      endcase
    end else if (in_acc) begin
      out_byte_d = '0;
      out_len_d  = '0;
      out_last_d = 1'b1;
      case (in_i.mode)
        MODE_WRITE: begin
          out_valid_d = 1'b1;
          out_kind_d  = wr_store ? KIND_WR_OK : KIND_WR_REJ;
          if (in_i.first_byte) begin
            rem_d  = (in_i.write_length != '0) ? in_i.write_length - WLEN_W'(1) : '0;
            drop_d = !wr_ok;
            if (pad_now) begin
              pad_d = tail[PTR_W-1:0];
            end
          end else if (rem_q != '0) begin
            rem_d = rem_q - WLEN_W'(1);
          end
          if (wr_store) begin
            wp_d   = (wp_inc >= cap_q) ? '0 : wp_inc[PTR_W-1:0];
            used_d = used_q + CNT_W'(1);
          end
        end
        MODE_READ: begin
          if (used_q == '0) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_RD_EMPTY;
          end else begin
            state_d   = ST_READ;
            rd_left_d = n_rd;
            rd_len_d  = n_rd;
          end
        end
        MODE_CLEAR: begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_CLEARED;
          wp_d        = '0;
          rp_d        = '0;
          used_d      = '0;
          pad_d       = '0;
          rem_d       = '0;
          drop_d      = 1'b0;
        end
        default: ;
      endcase
    end else if (state_q == ST_READ) begin
      if (load_rd) begin
        out_valid_d = 1'b1;
        out_kind_d  = KIND_RD_BYTE;
        out_byte_d  = rd_data;
        out_len_d   = rd_len_q;
        out_last_d  = pend_last_q;
        pend_d      = 1'b0;
      end
      if (issue) begin
        pend_d      = 1'b1;
        pend_last_d = (rd_left_q == RLEN_W'(1));
        rd_left_d   = rd_left_q - RLEN_W'(1);
        used_d      = used_q - CNT_W'(1);
        rp_d        = post_wrap ? '0 : rp_inc[PTR_W-1:0];
        pad_d       = post_wrap ? '0 : rd_pad;
      end
      if ((rd_left_q == '0) && !pend_q) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CNT_W'(DEPTH);
      pad_en_q    <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      used_q      <= '0;
      pad_q       <= '0;
      rem_q       <= '0;
      drop_q      <= 1'b0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      pad_en_q    <= pad_en_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      used_q      <= used_d;
      pad_q       <= pad_d;
      rem_q       <= rem_d;
      drop_q      <= drop_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_len_q    <= rd_len_d;
    pend_last_q <= pend_last_d;
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
  end

  // Byte store: writes on accepted bytes, reads while streaming a read
  brb_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && !cfg_we_i && (in_i.mode == MODE_WRITE) && wr_store),
    .wr_addr_i (wp_eff),
    .wr_data_i (in_i.data_byte),
    .rd_en_i   (issue && !cfg_we_i),
    .rd_addr_i (rd_rp),
    .rd_data_o (rd_data)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = out_kind_q;
  assign out_o.read_byte       = out_byte_q;
  assign out_o.returned_length = out_len_q;
  assign out_o.last            = out_last_q;

endmodule

// File: tb/sv/ring_check_pkg.sv
`timescale 1ns / 100ps

package ring_check_pkg;
  import brb_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] read_byte;
    logic [RLEN_W-1:0] returned_length;
    logic              last;
  } ring_result_t;

  // Shadow of the ring buffer: predicts the results of each transaction and
  // matches them against what the block returns.
  class ring_tracker;
    logic [BYTE_W-1:0] stored [DEPTH];
    logic [CNT_W-1:0]  capacity;
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  pad;
    logic [CNT_W-1:0]  left;
    bit                pad_on;
    bit                dropping;
    ring_result_t      expected_q [$];
    int unsigned       failures;
    int unsigned       items_taken;
    int unsigned       results_checked;
    int unsigned       pads_taken;
    int unsigned       kind_count [5];

    function new();
      capacity = CNT_W'(DEPTH);
      pad_on = 1'b0;
      empty_ring();
    endfunction

    function void empty_ring();
      wr_ptr = '0;
      rd_ptr = '0;
      fill = '0;
      pad = '0;
      left = '0;
      dropping = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_CAPACITY) begin
        if (value == 0) capacity = CNT_W'(1);
        else if (value > DEPTH) capacity = CNT_W'(DEPTH);
        else capacity = value;
        empty_ring();
      end else begin
        pad_on = value[0];
      end
    endfunction

    function void queue_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] rbyte,
                               logic [RLEN_W-1:0] total, logic last);
      expected_q.push_back('{kind: kind, read_byte: rbyte, returned_length: total, last: last});
    endfunction

    function void store_byte(logic [BYTE_W-1:0] data);
      stored[wr_ptr[PTR_W-1:0]] = data;
      wr_ptr = wr_ptr + CNT_W'(1);
      if (wr_ptr >= capacity) wr_ptr = '0;
      fill = fill + CNT_W'(1);
    endfunction

    // Reader passing the end of the used area wraps and releases the padding
    function void wrap_reader();
      if (rd_ptr >= capacity - pad) begin
        rd_ptr = '0;
        pad = '0;
      end
    endfunction

    function void take_item(logic [MODE_W-1:0] mode, logic first, logic [WLEN_W-1:0] wlen,
                            logic [BYTE_W-1:0] data, logic [RLEN_W-1:0] rlen);
      logic [CNT_W-1:0] room;
      logic [CNT_W-1:0] tail;
      bit               ok;
      int unsigned      want;
      int unsigned      n;
      items_taken++;
      case (mode)
        MODE_WRITE: begin
          if (first) begin
            room = capacity - fill - pad;
            ok = (wlen != 0) && (wlen <= room);
            if (ok && (fill == 0 || wr_ptr > rd_ptr)) begin
              tail = capacity - wr_ptr;
              if (wlen > tail && pad_on) begin
                if (wlen > rd_ptr) begin
                  ok = 1'b0;
                end else begin
                  pad = tail;
                  wr_ptr = '0;
                  pads_taken++;
                end
              end
            end
            left = (wlen != 0) ? wlen - WLEN_W'(1) : '0;
            dropping = !ok;
            if (ok) store_byte(data);
            queue_result(ok ? KIND_WR_OK : KIND_WR_REJ, '0, '0, 1'b1);
          end else if (left == 0) begin
            queue_result(KIND_WR_REJ, '0, '0, 1'b1);
          end else begin
            left = left - CNT_W'(1);
            if (dropping) begin
              queue_result(KIND_WR_REJ, '0, '0, 1'b1);
            end else begin
              store_byte(data);
              queue_result(KIND_WR_OK, '0, '0, 1'b1);
            end
          end
        end
        MODE_READ: begin
          want = (rlen == 0) ? 1 : ((rlen > MAX_READ) ? MAX_READ : 32'(rlen));
          if (fill == 0) begin
            queue_result(KIND_RD_EMPTY, '0, '0, 1'b1);
          end else begin
            n = (want < fill) ? want : 32'(fill);
            for (int unsigned k = 0; k < n; k++) begin
              wrap_reader();
              queue_result(KIND_RD_BYTE, stored[rd_ptr[PTR_W-1:0]], RLEN_W'(n), k + 1 == n);
              rd_ptr = rd_ptr + CNT_W'(1);
            end
            wrap_reader();
            fill = fill - CNT_W'(n);
          end
        end
        MODE_CLEAR: begin
          empty_ring();
          queue_result(KIND_CLEARED, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void match_result(ring_result_t got);
      ring_result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: kind %0d, read_byte %0d", got.kind, got.read_byte);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (want.kind < 5) kind_count[want.kind]++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        failures++;
      end
      if (got.read_byte !== want.read_byte) begin
        $error("read_byte: expected %0d, actual %0d", want.read_byte, got.read_byte);
        failures++;
      end
      if (got.returned_length !== want.returned_length) begin
        $error("returned_length: expected %0d, actual %0d",
               want.returned_length, got.returned_length);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import brb_pkg::*;
  import ring_check_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 5;
  // a read issues one byte per cycle while results are taken, and the block goes
  // idle once it ends, so these idle cycles cover any work still in flight
  localparam int unsigned DRAIN_CYCLES    = 8;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PHASES          = 11;
  localparam int unsigned ITEMS_PER_PHASE = 35;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  brb_in_if  in_ch ();
  brb_out_if out_ch ();

  byte_ring_buffer_with_padding_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ring_tracker ring;
  bit          steady;           // 1: neither side idles during this stretch
  int unsigned stimulus_count;   // transactions that cause a result
  int unsigned quiet_cycles;

  // Capacity/padding plan for the random phases; 0 and 2047 check clamping
  int unsigned cap_plan [PHASES] = '{0, 1, 4, 8, 16, 24, 37, 64, 100, 2047, 1024};
  bit          pad_plan [PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 1, 0};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // One input transaction: optional idle gap, then hold valid until taken.
  // With a zero gap valid stays high and only the payload changes.
  task automatic send_item(logic [MODE_W-1:0] mode, logic first, logic [WLEN_W-1:0] wlen,
                           logic [BYTE_W-1:0] data, logic [RLEN_W-1:0] rlen);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.first_byte   <= first;
    in_ch.write_length <= wlen;
    in_ch.data_byte    <= data;
    in_ch.read_length  <= rlen;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (mode != MODE_NOP) stimulus_count++;
  endtask

  // Random draws come in as plain integers and are cut to the field widths
  task automatic send_draw(logic [MODE_W-1:0] mode, int unsigned first, int unsigned wlen,
                           int unsigned data, int unsigned rlen);
    send_item(mode, 1'(first), WLEN_W'(wlen), BYTE_W'(data), RLEN_W'(rlen));
  endtask

  // Drop valid, wait for every pending result, then let the block go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (ring.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write: enable high for one cycle, then low again before the task returns
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ring.set_register(idx, value);
    @(posedge clk_i);
  endtask

  // Result side: random ready stalls per result transaction
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
    end
  end

  // Monitor: inputs are predicted before results are matched, so a result
  // taken in the same cycle as its cause still finds its expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        ring.take_item(in_ch.mode, in_ch.first_byte, in_ch.write_length,
                       in_ch.data_byte, in_ch.read_length);
      if (out_ch.valid && out_ch.ready)
        ring.match_result('{kind: out_ch.kind, read_byte: out_ch.read_byte,
                            returned_length: out_ch.returned_length, last: out_ch.last});
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles", quiet_cycles);
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned target;
    int unsigned span;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    ring = new();
    steady = 1'b0;
    stimulus_count = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CAPACITY;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NOP;
    in_ch.first_byte = 1'b0;
    in_ch.write_length = '0;
    in_ch.data_byte = '0;
    in_ch.read_length = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings (full capacity, no padding)
    send_item(MODE_READ,  1'b0, 11'd0,    8'h00, 7'd0);    // empty read, length 0 -> 1
    send_item(MODE_WRITE, 1'b0, 11'd2047, 8'hFF, 7'd127);  // stray byte
    send_item(MODE_WRITE, 1'b1, 11'd0,    8'h11, 7'd0);    // zero length refused
    send_item(MODE_WRITE, 1'b0, 11'd0,    8'h22, 7'd0);    // nothing open
    send_item(MODE_WRITE, 1'b1, 11'd2047, 8'h33, 7'd0);    // too long, dropped
    send_item(MODE_WRITE, 1'b0, 11'd0,    8'h44, 7'd0);    // byte of dropped transfer
    send_item(MODE_WRITE, 1'b1, 11'd1024, 8'hFF, 7'd0);    // whole store, taken
    send_item(MODE_WRITE, 1'b0, 11'd0,    8'h00, 7'd0);
    send_item(MODE_WRITE, 1'b1, 11'd3,    8'hA5, 7'd0);    // new first byte ends the open one
    send_item(MODE_WRITE, 1'b0, 11'd0,    8'h5A, 7'd0);
    send_item(MODE_READ,  1'b0, 11'd0,    8'h00, 7'd2);
    send_item(MODE_NOP,   1'b1, 11'd7,    8'h77, 7'd9);    // ignored
    send_item(MODE_READ,  1'b0, 11'd0,    8'h00, 7'd65);   // clamped to the read limit
    send_item(MODE_WRITE, 1'b1, 11'd2,    8'h3C, 7'd0);
    send_item(MODE_CLEAR, 1'b0, 11'd0,    8'h00, 7'd0);    // clear closes the transfer
    send_item(MODE_WRITE, 1'b0, 11'd0,    8'hC3, 7'd0);
    send_item(MODE_READ,  1'b0, 11'd0,    8'h00, 7'd64);
    settle();

    // Directed padding: capacity 4, a transfer that skips the tail, the
    // reader wrapping past the padding, then a tail skip that cannot fit
    write_register(CFG_CAPACITY, 11'd4);
    write_register(CFG_PAD_EN, 11'd1);
    send_item(MODE_WRITE, 1'b1, 11'd3, 8'h01, 7'd0);
    send_item(MODE_WRITE, 1'b0, 11'd0, 8'h02, 7'd0);
    send_item(MODE_WRITE, 1'b0, 11'd0, 8'h03, 7'd0);
    send_item(MODE_READ,  1'b0, 11'd0, 8'h00, 7'd2);
    send_item(MODE_WRITE, 1'b1, 11'd2, 8'h04, 7'd0);    // pads the last slot
    send_item(MODE_WRITE, 1'b0, 11'd0, 8'h05, 7'd0);
    send_item(MODE_READ,  1'b0, 11'd0, 8'h00, 7'd64);   // wraps over the padding
    send_item(MODE_WRITE, 1'b1, 11'd3, 8'h06, 7'd0);    // front too small, refused
    settle();

    // Random phases: mostly complete transfers with reads mixed in, plus
    // truncated transfers, stray bytes, odd lengths, clears and idle codes
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_register(CFG_CAPACITY, CFG_DATA_W'(cap_plan[p]));
      write_register(CFG_PAD_EN, CFG_DATA_W'(pad_plan[p]));
      steady = (p % 3 == 2);
      span = (ring.capacity < 16) ? 32'(ring.capacity) : 16;
      target = stimulus_count + ITEMS_PER_PHASE;
      while (stimulus_count < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = $urandom_range(1, span);
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
          send_draw(MODE_WRITE, 1, len, $urandom_range(0, 255), $urandom_range(0, 127));
          for (int unsigned k = 1; k < cut; k++) begin
            if ($urandom_range(0, 7) == 0)
              send_draw(MODE_READ, $urandom_range(0, 1), $urandom_range(0, 2047),
                        $urandom_range(0, 255), $urandom_range(1, span));
            send_draw(MODE_WRITE, 0, $urandom_range(0, 2047), $urandom_range(0, 255),
                      $urandom_range(0, 127));
          end
        end else if (pick < 80) begin
          send_draw(MODE_READ, $urandom_range(0, 1), $urandom_range(0, 2047),
                    $urandom_range(0, 255),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, span));
        end else if (pick < 88) begin
          send_draw(MODE_WRITE, 0, $urandom_range(0, 2047), $urandom_range(0, 255),
                    $urandom_range(0, 127));
        end else if (pick < 93) begin
          send_draw(MODE_WRITE, 1, $urandom_range(0, 2047), $urandom_range(0, 255),
                    $urandom_range(0, 127));
        end else if (pick < 97) begin
          send_draw(MODE_CLEAR, $urandom_range(0, 1), $urandom_range(0, 2047),
                    $urandom_range(0, 255), $urandom_range(0, 127));
        end else begin
          send_draw(MODE_NOP, $urandom_range(0, 1), $urandom_range(0, 2047),
                    $urandom_range(0, 255), $urandom_range(0, 127));
        end
      end
      settle();
    end

    $display("covered %0d input transactions, %0d results over %0d register settings",
             ring.items_taken, ring.results_checked, PHASES + 2);
    $display("writes taken %0d, refused %0d, bytes read %0d, empty reads %0d, clears %0d, pads %0d",
             ring.kind_count[KIND_WR_OK], ring.kind_count[KIND_WR_REJ],
             ring.kind_count[KIND_RD_BYTE], ring.kind_count[KIND_RD_EMPTY],
             ring.kind_count[KIND_CLEARED], ring.pads_taken);
    if (ring.failures == 0 && ring.expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
